/* src/ips_pkg.sv */
// ---------------------------------------------------------------------------
// ips_pkg
// Shared constants, command codes and store port types for the indexed
// page search block.
// ---------------------------------------------------------------------------
package ips_pkg;

  localparam int PAGE_SIZE = 8;
  localparam int MAX_PAGES = 64;
  localparam int CAPACITY  = PAGE_SIZE * MAX_PAGES;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COMP_W  = 8;
  localparam int REC_AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PAGE_AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
  localparam int SLOT_W  = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;
  localparam int OFS_W   = $clog2(PAGE_SIZE + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // write side of the record store and page index
  typedef struct packed {
    logic               rec_we;
    logic [REC_AW-1:0]  rec_addr;
    logic [KEY_W-1:0]   rec_key;
    logic [DATA_W-1:0]  rec_data;
    logic               idx_we;
    logic [PAGE_AW-1:0] idx_addr;
  } ips_wr_t;

  // read addresses, data comes back from a registered read
  typedef struct packed {
    logic [REC_AW-1:0]  rec_addr;
    logic [PAGE_AW-1:0] idx_addr;
  } ips_rd_t;

endpackage

/* src/ips_store.sv */
// ---------------------------------------------------------------------------
// ips_store
// Record memory (key and payload) and page index memory, one write and
// one registered read port each.
// ---------------------------------------------------------------------------
module ips_store import ips_pkg::*; (
  input  logic               clk,
  input  ips_wr_t            wr,
  input  ips_rd_t            rd,
  output logic [KEY_W-1:0]   idx_rd_key,
  output logic [KEY_W-1:0]   rec_rd_key,
  output logic [DATA_W-1:0]  rec_rd_data
);

  logic [KEY_W+DATA_W-1:0] rec_mem [CAPACITY];
  logic [KEY_W-1:0]        idx_mem [MAX_PAGES];
  logic [KEY_W+DATA_W-1:0] rec_q_r;
  logic [KEY_W-1:0]        idx_q_r;

  always_ff @(posedge clk) begin
    if (wr.rec_we) begin
      rec_mem[wr.rec_addr] <= {wr.rec_data, wr.rec_key};
    end
    rec_q_r <= rec_mem[rd.rec_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.idx_we) begin
      idx_mem[wr.idx_addr] <= wr.rec_key;
    end
    idx_q_r <= idx_mem[rd.idx_addr];
  end

  assign idx_rd_key  = idx_q_r;
  assign rec_rd_key  = rec_q_r[KEY_W-1:0];
  assign rec_rd_data = rec_q_r[KEY_W+DATA_W-1:KEY_W];

endmodule

/* src/indexed_page_search.sv */
// ---------------------------------------------------------------------------
// indexed_page_search
// Sorted record store with a page index: load appends a record, search
// scans the page index and then binary-searches the chosen page.
// ---------------------------------------------------------------------------
//  channel   direction  tuser                      tdata
//  in_       slave      [1:0] command              [31:0] key, [63:32] data
//  out_      master     [0] found, [1] store_full  [31:0] record_key,
//                                                  [63:32] record_data,
//                                                  [71:64] comparisons
//
//  clear, load and a search of an empty store finish as they are accepted.
//  any other search reads the page index in the scan (pages passed, plus the
//  page that stops it), then makes binary-search probes (issue and compare
//  on the record memory port), and a last issue state when the binary search
//  ends without a match.
//  reset empties the store; the memories themselves are not cleared.
//  a request is taken while the previous result waits in the output
//  register; a finished result then holds the block until that slot frees.
// ---------------------------------------------------------------------------
module indexed_page_search import ips_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [0] found, [1] store_full
  output logic [71:0] out_tdata   // [31:0] record_key, [63:32] record_data,
                                  // [71:64] comparisons
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BS_ISSUE,
    ST_BS_CMP,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PCNT_W-1:0]   pages_r;

  logic [KEY_W-1:0]    q_r;
  logic [COMP_W-1:0]   comps_r;
  logic [PCNT_W-1:0]   p_r;
  logic [PAGE_AW-1:0]  page_sel_r;
  logic [OFS_W-1:0]    lo_r;
  logic [OFS_W-1:0]    hi1_r;
  logic [OFS_W-1:0]    mid_r;

  logic                out_valid_r;
  logic                out_found_r;
  logic                out_full_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [COMP_W-1:0]   out_comps_r;

  logic                res_found_r;
  logic                res_full_r;
  logic [KEY_W-1:0]    res_key_r;
  logic [DATA_W-1:0]   res_data_r;
  logic [COMP_W-1:0]   res_comps_r;

  ips_wr_t             wr;
  ips_rd_t             rd;
  logic [KEY_W-1:0]    idx_rd_key;
  logic [KEY_W-1:0]    rec_rd_key;
  logic [DATA_W-1:0]   rec_rd_data;

  logic                accept;
  logic [1:0]          cmd;
  logic [KEY_W-1:0]    in_key;
  logic [DATA_W-1:0]   in_data;
  logic                is_full;
  logic                slot_free;
  logic                page_le;
  logic [PCNT_W-1:0]   p_inc;
  logic                scan_end;
  logic [PCNT_W-1:0]   scan_i;
  logic [OFS_W:0]      mid_sum;
  logic [OFS_W-1:0]    mid;
  logic                key_eq;
  logic                key_lt;

  logic                fin;
  logic                fin_found;
  logic                fin_full;
  logic [KEY_W-1:0]    fin_key;
  logic [DATA_W-1:0]   fin_data;
  logic [COMP_W-1:0]   fin_comps;

  ips_store u_store (
    .clk         (clk),
    .wr          (wr),
    .rd          (rd),
    .idx_rd_key  (idx_rd_key),
    .rec_rd_key  (rec_rd_key),
    .rec_rd_data (rec_rd_data)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign in_key    = in_tdata[KEY_W-1:0];
  assign in_data   = in_tdata[KEY_W+DATA_W-1:KEY_W];
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign slot_free = !out_valid_r || out_tready;

  // index scan: data of page p_r arrives while page p_r+1 is read
  assign page_le  = ($signed(idx_rd_key) <= $signed(q_r));
  assign p_inc    = p_r + PCNT_W'(1);
  assign scan_end = !page_le || (p_inc == pages_r);
  assign scan_i   = page_le ? p_inc : p_r;

  // lo + (hi - lo) / 2 with hi = hi1 - 1, lo < hi1 here
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (OFS_W+1)'(1);
  assign mid     = mid_sum[OFS_W:1];

  assign key_eq = (rec_rd_key == q_r);
  assign key_lt = ($signed(rec_rd_key) < $signed(q_r));

  always_comb begin
    wr          = '0;
    wr.rec_addr = count_r[REC_AW-1:0];
    wr.rec_key  = in_key;
    wr.rec_data = in_data;
    wr.idx_addr = pages_r[PAGE_AW-1:0];
    if (accept && cmd == CMD_LOAD && !is_full) begin
      wr.rec_we = 1'b1;
      wr.idx_we = (slot_r == '0);
    end
  end

  always_comb begin
    rd.idx_addr = '0;
    rd.rec_addr = REC_AW'(page_sel_r * PAGE_SIZE) + REC_AW'(mid);
    if (state_r == ST_SCAN) begin
      rd.idx_addr = p_inc[PAGE_AW-1:0];
    end
  end

  always_comb begin
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_full  = 1'b0;
    fin_key   = '0;
    fin_data  = '0;
    fin_comps = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_SEARCH) begin
            if (pages_r == '0) begin
              fin       = 1'b1;
              fin_comps = COMP_W'(1);
            end
          end else begin
            fin      = 1'b1;
            fin_full = (cmd == CMD_LOAD) && is_full;
          end
        end
      end
      ST_SCAN: begin
        // key below the first page
        if (scan_end && scan_i == '0) begin
          fin       = 1'b1;
          fin_comps = comps_r;
        end
      end
      ST_BS_ISSUE: begin
        if (lo_r >= hi1_r) begin
          fin       = 1'b1;
          fin_comps = comps_r;
        end
      end
      ST_BS_CMP: begin
        if (key_eq) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_key   = rec_rd_key;
          fin_data  = rec_rd_data;
          fin_comps = comps_r + COMP_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      slot_r      <= '0;
      pages_r     <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            q_r     <= in_key;
            comps_r <= COMP_W'(1);
            p_r     <= '0;
            case (cmd)
              CMD_CLEAR: begin
                count_r <= '0;
                slot_r  <= '0;
                pages_r <= '0;
              end
              CMD_LOAD: begin
                if (!is_full) begin
                  count_r <= count_r + CNT_W'(1);
                  if (slot_r == '0) begin
                    pages_r <= pages_r + PCNT_W'(1);
                  end
                  slot_r <= (slot_r == SLOT_W'(PAGE_SIZE - 1)) ? '0
                                                                : slot_r + SLOT_W'(1);
                end
              end
              CMD_SEARCH: begin
                if (pages_r != '0) begin
                  state_r <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (page_le) begin
            comps_r <= comps_r + COMP_W'(1);
            p_r     <= p_inc;
          end
          if (scan_end && scan_i != '0) begin
            page_sel_r <= PAGE_AW'(scan_i - PCNT_W'(1));
            lo_r       <= '0;
            // partial last page
            if (scan_i == pages_r && slot_r != '0) begin
              hi1_r <= OFS_W'(slot_r);
            end else begin
              hi1_r <= OFS_W'(PAGE_SIZE);
            end
            state_r <= ST_BS_ISSUE;
          end
        end
        ST_BS_ISSUE: begin
          if (lo_r < hi1_r) begin
            mid_r   <= mid;
            state_r <= ST_BS_CMP;
          end
        end
        ST_BS_CMP: begin
          if (!key_eq) begin
            comps_r <= comps_r + COMP_W'(2);
            if (key_lt) begin
              lo_r <= mid_r + OFS_W'(1);
            end else begin
              hi1_r <= mid_r;
            end
            state_r <= ST_BS_ISSUE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_full_r  <= res_full_r;
            out_key_r   <= res_key_r;
            out_data_r  <= res_data_r;
            out_comps_r <= res_comps_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (fin) begin
        if (slot_free) begin
          out_valid_r <= 1'b1;
          out_found_r <= fin_found;
          out_full_r  <= fin_full;
          out_key_r   <= fin_key;
          out_data_r  <= fin_data;
          out_comps_r <= fin_comps;
          state_r     <= ST_IDLE;
        end else begin
          res_found_r <= fin_found;
          res_full_r  <= fin_full;
          res_key_r   <= fin_key;
          res_data_r  <= fin_data;
          res_comps_r <= fin_comps;
          state_r     <= ST_DONE;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_full_r, out_found_r};
  assign out_tdata  = {out_comps_r, out_data_r, out_key_r};

endmodule
